// ===== rtl/bsv_pkg.sv =====
`timescale 1ns / 1ps

package bsv_pkg;

  // default build values
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;

  // fixed field widths
  localparam int COORD_W    = 32;
  localparam int SEG_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // derivative after rounding: 38 bit signed, independent of fraction bits
  localparam int DCW = 38;

  // square root unit: one result bit per stage
  localparam int SQRT_STAGES = 32;
  localparam int RAD_W       = 2 * SQRT_STAGES;

  // register reset values
  localparam logic [63:0] POINT_0_RST  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] POINT_1_RST  = 64'h0028_0000_0000_0000;
  localparam logic [63:0] POINT_2_RST  = 64'h0028_0000_0000_0000;
  localparam logic [63:0] POINT_3_RST  = 64'h0028_0000_0028_0000;
  localparam logic [31:0] WIDTH_RST    = 32'h0005_0000;
  localparam logic [8:0]  SEG_CNT_RST  = 9'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_0       = 3'd0,
    REG_POINT_1       = 3'd1,
    REG_POINT_2       = 3'd2,
    REG_POINT_3       = 3'd3,
    REG_STRIP_WIDTH   = 3'd4,
    REG_SEGMENT_COUNT = 3'd5
  } cfg_reg_t;

  // per-item data that rides alongside the tangent path
  typedef struct packed {
    logic                  degen;
    logic                  neg_x;
    logic                  neg_y;
    logic signed [DCW-1:0] pc_x;
    logic signed [DCW-1:0] pc_y;
  } sb_t;

endpackage

// ===== rtl/bsv_div_pipe.sv =====
`timescale 1ns / 1ps

module bsv_div_pipe #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 32,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic [QUO_W-1:0] quo
);

  // restoring division, one quotient bit per stage, msb first
  logic [DVS_W-1:0] rem_r   [QUO_W];
  logic [DVS_W-1:0] dvs_r   [QUO_W];
  logic [QUO_W-1:0] low_r   [QUO_W];
  logic [QUO_W-1:0] q_r     [QUO_W];
  logic [DVS_W-1:0] rem_in  [QUO_W];
  logic [DVS_W-1:0] dvs_in  [QUO_W];
  logic [QUO_W-1:0] low_in  [QUO_W];
  logic [QUO_W-1:0] q_in    [QUO_W];
  logic [DVS_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] q_nxt   [QUO_W];

  always_comb begin
    rem_in[0] = DVS_W'(dvd >> QUO_W);
    dvs_in[0] = dvs;
    low_in[0] = dvd[QUO_W-1:0];
    q_in[0]   = '0;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k] = rem_r[k-1];
      dvs_in[k] = dvs_r[k-1];
      low_in[k] = low_r[k-1];
      q_in[k]   = q_r[k-1];
    end
  end

  always_comb begin
    logic [DVS_W:0] trial;
    logic           ge;
    for (int k = 0; k < QUO_W; k++) begin
      trial      = {rem_in[k], low_in[k][QUO_W-1]};
      ge         = (trial >= {1'b0, dvs_in[k]});
      rem_nxt[k] = ge ? DVS_W'(trial - {1'b0, dvs_in[k]}) : trial[DVS_W-1:0];
      q_nxt[k]   = {q_in[k][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_in[k];
        low_r[k] <= low_in[k] << 1;
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign quo = q_r[QUO_W-1];

endmodule

// ===== rtl/bsv_sqrt_pipe.sv =====
`timescale 1ns / 1ps

module bsv_sqrt_pipe (
  input  logic                            clk,
  input  logic                            en,
  input  logic [bsv_pkg::RAD_W-1:0]       rad,
  output logic [bsv_pkg::SQRT_STAGES-1:0] root
);

  import bsv_pkg::*;

  // floor square root, digit by digit, one root bit per stage
  logic [RAD_W-1:0] rad_r   [SQRT_STAGES];
  logic [RAD_W-1:0] res_r   [SQRT_STAGES];
  logic [RAD_W-1:0] rad_in  [SQRT_STAGES];
  logic [RAD_W-1:0] res_in  [SQRT_STAGES];
  logic [RAD_W-1:0] rad_nxt [SQRT_STAGES];
  logic [RAD_W-1:0] res_nxt [SQRT_STAGES];

  always_comb begin
    rad_in[0] = rad;
    res_in[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      rad_in[k] = rad_r[k-1];
      res_in[k] = res_r[k-1];
    end
  end

  always_comb begin
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      trial = res_in[k] + bitv;
      if (rad_in[k] >= trial) begin
        rad_nxt[k] = rad_in[k] - trial;
        res_nxt[k] = (res_in[k] >> 1) + bitv;
      end else begin
        rad_nxt[k] = rad_in[k];
        res_nxt[k] = res_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rad_r[k] <= rad_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][SQRT_STAGES-1:0];

endmodule

// ===== rtl/bezier_strip_vertex_pair.sv =====
`timescale 1ns / 1ps

// Road strip edge evaluator. Each item carries a sample index i; the block
// forms u = i / segment_count, evaluates the cubic Bezier point and its
// derivative from the four configured control points, normalizes the tangent
// and emits the left and right edge points offset by half the strip width,
// all in signed fixed point with FRAC_BITS fraction bits, saturated to 32
// bits. A zero derivative sets degenerate_tangent and both edges then equal
// the curve point. The block takes one item every clock unless the output
// stalls and returns one result per item. The pipeline holds bit-per-stage
// dividers for u and for the x and y unit tangent parts (each FRAC_BITS+1
// stages) and the 32-stage square root for the tangent length. The whole
// pipeline advances together; it holds while a result waits at the output
// register. The user writes configuration through cfg_we/cfg_index/
// cfg_wdata while no item is in flight; the block does not enforce this.
// There is no memory and no clearing pass after reset.

module bezier_strip_vertex_pair #(
  parameter int MAX_SEGMENTS = bsv_pkg::MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS    = bsv_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bsv_pkg::SEG_W-1:0]        in_sample_index,
  // result out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bsv_pkg::COORD_W-1:0] out_left_x,
  output logic signed [bsv_pkg::COORD_W-1:0] out_left_y,
  output logic signed [bsv_pkg::COORD_W-1:0] out_right_x,
  output logic signed [bsv_pkg::COORD_W-1:0] out_right_y,
  output logic                             out_degenerate_tangent,
  // register writes
  input  logic                             cfg_we,
  input  logic [bsv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import bsv_pkg::*;

  // widths derived from the fraction bits
  localparam int UW   = FRAC_BITS + 1;        // u, v and their products
  localparam int UW2  = 2 * UW;
  localparam int WW   = FRAC_BITS + 5;        // signed curve weights
  localparam int PW   = WW + COORD_W;         // coordinate times weight
  localparam int SW   = DCW + FRAC_BITS;      // sum of four products
  localparam int PSW  = $clog2(DCW);          // msb position
  localparam int NMW  = 31;                   // normalized derivative
  localparam int TDW  = FRAC_BITS + 32;       // tangent dividend
  localparam int TW   = FRAC_BITS + 1;        // unit tangent magnitude
  localparam int OPW  = TW + 32;              // tangent times width
  localparam int RW   = 32;                   // rounded offset
  localparam int EW   = DCW + 2;              // edge sum before saturation
  localparam int SB_D = 7 + SQRT_STAGES + TW; // sideband delay
  localparam int NSTG = 1 + UW + 7 + SB_D;    // stages before output reg

  localparam logic [UW-1:0]        U_ONE  = UW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] S_HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic [OPW-1:0]       O_HALF = OPW'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] S_MAX  = EW'(32'sh7fff_ffff);
  localparam logic signed [EW-1:0] S_MIN  = EW'(32'sh8000_0000);

  // round half up of a product to FRAC_BITS fraction bits
  function automatic logic [UW-1:0] mul_frac(input logic [UW-1:0] a,
                                             input logic [UW-1:0] b);
    logic [UW2-1:0] p;
    p = UW2'(a) * UW2'(b);
    p = p + (UW2'(1) << (FRAC_BITS - 1));
    return UW'(p >> FRAC_BITS);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = x;
    if (x > S_MAX) y = S_MAX;
    if (x < S_MIN) y = S_MIN;
    return y[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [63:0]      pt_r [4];
  logic [31:0]      wid_r;
  logic [SEG_W-1:0] seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0] <= POINT_0_RST;
      pt_r[1] <= POINT_1_RST;
      pt_r[2] <= POINT_2_RST;
      pt_r[3] <= POINT_3_RST;
      wid_r   <= WIDTH_RST;
      seg_r   <= SEG_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_0:       pt_r[0] <= cfg_wdata;
        REG_POINT_1:       pt_r[1] <= cfg_wdata;
        REG_POINT_2:       pt_r[2] <= cfg_wdata;
        REG_POINT_3:       pt_r[3] <= cfg_wdata;
        REG_STRIP_WIDTH:   wid_r   <= cfg_wdata[31:0];
        REG_SEGMENT_COUNT: seg_r   <= cfg_wdata[SEG_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: everything moves together when the output can take
  // ---------------------------------------------------------------------
  logic pipe_en;
  logic vld_r [NSTG];
  logic out_valid_r;

  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: clamp segment count and sample index
  // ---------------------------------------------------------------------
  logic [SEG_W-1:0] i1_r, n1_r;
  logic [SEG_W-1:0] n1_nxt, i1_nxt;

  always_comb begin
    n1_nxt = seg_r;
    if (n1_nxt == '0) n1_nxt = SEG_W'(1);
    if (int'(n1_nxt) > MAX_SEGMENTS) n1_nxt = MAX_SEGMENTS[SEG_W-1:0];
    i1_nxt = in_sample_index;
    if (i1_nxt > n1_nxt) i1_nxt = n1_nxt;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      i1_r <= i1_nxt;
      n1_r <= n1_nxt;
    end
  end

  // u = floor(i * 2^F / n), one bit per stage
  logic [UW-1:0] u_q;

  bsv_div_pipe #(
    .DVD_W(SEG_W + FRAC_BITS),
    .DVS_W(SEG_W),
    .QUO_W(UW)
  ) u_udiv (
    .clk (clk),
    .en  (pipe_en),
    .dvd ({i1_r, {FRAC_BITS{1'b0}}}),
    .dvs (n1_r),
    .quo (u_q)
  );

  // ---------------------------------------------------------------------
  // stages a..c: basis weights
  // ---------------------------------------------------------------------
  logic [UW-1:0] u_a_r, v_a_r;
  logic [UW-1:0] u_b_r, v_b_r, uu_b_r, vv_b_r, uv_b_r;
  logic signed [WW-1:0] bw_c_r [4];
  logic signed [WW-1:0] dw_c_r [4];
  logic signed [WW-1:0] bw_nxt [4];
  logic signed [WW-1:0] dw_nxt [4];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      u_a_r  <= u_q;
      v_a_r  <= U_ONE - u_q;
      u_b_r  <= u_a_r;
      v_b_r  <= v_a_r;
      uu_b_r <= mul_frac(u_a_r, u_a_r);
      vv_b_r <= mul_frac(v_a_r, v_a_r);
      uv_b_r <= mul_frac(u_a_r, v_a_r);
    end
  end

  // point weights v^3, 3uv^2, 3u^2v, u^3; derivative weights from uu, vv, uv
  always_comb begin
    logic signed [WW-1:0] vvs, uus, uvs;
    vvs = $signed(WW'(vv_b_r));
    uus = $signed(WW'(uu_b_r));
    uvs = $signed(WW'(uv_b_r));
    bw_nxt[0] = $signed(WW'(mul_frac(vv_b_r, v_b_r)));
    bw_nxt[1] = $signed(WW'(3 * mul_frac(vv_b_r, u_b_r)));
    bw_nxt[2] = $signed(WW'(3 * mul_frac(uu_b_r, v_b_r)));
    bw_nxt[3] = $signed(WW'(mul_frac(uu_b_r, u_b_r)));
    dw_nxt[0] = WW'(-3 * vvs);
    dw_nxt[1] = WW'(3 * vvs - 6 * uvs);
    dw_nxt[2] = WW'(6 * uvs - 3 * uus);
    dw_nxt[3] = WW'(3 * uus);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        bw_c_r[k] <= bw_nxt[k];
        dw_c_r[k] <= dw_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stages d..f: weighted sums per axis, then round to F fraction bits
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]  pp_d_r [2][4];
  logic signed [PW-1:0]  pd_d_r [2][4];
  logic signed [PW-1:0]  pp_nxt [2][4];
  logic signed [PW-1:0]  pd_nxt [2][4];
  logic signed [SW-1:0]  ps_e_r [2];
  logic signed [SW-1:0]  ds_e_r [2];
  logic signed [DCW-1:0] pc_f_r [2];
  logic signed [DCW-1:0] dc_f_r [2];

  always_comb begin
    logic signed [COORD_W-1:0] crd;
    for (int ax = 0; ax < 2; ax++) begin
      for (int k = 0; k < 4; k++) begin
        // x in the upper word, y in the lower
        crd = (ax == 0) ? $signed(pt_r[k][63:32]) : $signed(pt_r[k][31:0]);
        pp_nxt[ax][k] = PW'(crd) * PW'(bw_c_r[k]);
        pd_nxt[ax][k] = PW'(crd) * PW'(dw_c_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int ax = 0; ax < 2; ax++) begin
        for (int k = 0; k < 4; k++) begin
          pp_d_r[ax][k] <= pp_nxt[ax][k];
          pd_d_r[ax][k] <= pd_nxt[ax][k];
        end
        ps_e_r[ax] <= SW'(pp_d_r[ax][0]) + SW'(pp_d_r[ax][1])
                    + SW'(pp_d_r[ax][2]) + SW'(pp_d_r[ax][3]);
        ds_e_r[ax] <= SW'(pd_d_r[ax][0]) + SW'(pd_d_r[ax][1])
                    + SW'(pd_d_r[ax][2]) + SW'(pd_d_r[ax][3]);
        // round half up is a floor of the biased value
        pc_f_r[ax] <= DCW'((ps_e_r[ax] + S_HALF) >>> FRAC_BITS);
        dc_f_r[ax] <= DCW'((ds_e_r[ax] + S_HALF) >>> FRAC_BITS);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stages g..k: magnitudes, normalize to [2^30, 2^31), squares, sum
  // ---------------------------------------------------------------------
  sb_t              sb_g_r;
  logic [DCW-1:0]   mx_g_r, my_g_r;
  logic [PSW-1:0]   msb_h_r;
  logic [PSW-1:0]   msb_nxt;
  logic [DCW-1:0]   mx_h_r, my_h_r;
  logic [NMW-1:0]   mxn_i_r, myn_i_r;
  logic [NMW-1:0]   mxn_nxt, myn_nxt;
  logic [2*NMW-1:0] sqx_j_r, sqy_j_r;
  logic [NMW-1:0]   mxn_j_r, myn_j_r;
  logic [RAD_W-1:0] rad_k_r;
  logic [NMW-1:0]   mxn_k_r, myn_k_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb_g_r.degen <= (dc_f_r[0] == '0) && (dc_f_r[1] == '0);
      sb_g_r.neg_x <= dc_f_r[0][DCW-1];
      sb_g_r.neg_y <= dc_f_r[1][DCW-1];
      sb_g_r.pc_x  <= pc_f_r[0];
      sb_g_r.pc_y  <= pc_f_r[1];
      mx_g_r <= dc_f_r[0][DCW-1] ? DCW'(-dc_f_r[0]) : DCW'(dc_f_r[0]);
      my_g_r <= dc_f_r[1][DCW-1] ? DCW'(-dc_f_r[1]) : DCW'(dc_f_r[1]);
    end
  end

  // leading one of the larger magnitude (the or has the same msb)
  always_comb begin
    logic [DCW-1:0] orv;
    orv     = mx_g_r | my_g_r;
    msb_nxt = '0;
    for (int j = 0; j < DCW; j++) begin
      if (orv[j]) msb_nxt = PSW'(j);
    end
  end

  // downscale truncates, upscale fills zeros
  always_comb begin
    if (msb_h_r > PSW'(NMW - 1)) begin
      mxn_nxt = NMW'(mx_h_r >> (msb_h_r - PSW'(NMW - 1)));
      myn_nxt = NMW'(my_h_r >> (msb_h_r - PSW'(NMW - 1)));
    end else begin
      mxn_nxt = NMW'(mx_h_r << (PSW'(NMW - 1) - msb_h_r));
      myn_nxt = NMW'(my_h_r << (PSW'(NMW - 1) - msb_h_r));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      msb_h_r <= msb_nxt;
      mx_h_r  <= mx_g_r;
      my_h_r  <= my_g_r;
      mxn_i_r <= mxn_nxt;
      myn_i_r <= myn_nxt;
      sqx_j_r <= (2*NMW)'(mxn_i_r) * (2*NMW)'(mxn_i_r);
      sqy_j_r <= (2*NMW)'(myn_i_r) * (2*NMW)'(myn_i_r);
      mxn_j_r <= mxn_i_r;
      myn_j_r <= myn_i_r;
      rad_k_r <= RAD_W'(sqx_j_r) + RAD_W'(sqy_j_r);
      mxn_k_r <= mxn_j_r;
      myn_k_r <= myn_j_r;
    end
  end

  // tangent length
  logic [SQRT_STAGES-1:0] len_q;

  bsv_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (pipe_en),
    .rad  (rad_k_r),
    .root (len_q)
  );

  // normalized components wait out the square root
  logic [NMW-1:0] mxn_dl_r [SQRT_STAGES];
  logic [NMW-1:0] myn_dl_r [SQRT_STAGES];
  sb_t            sb_dl_r  [SB_D];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mxn_dl_r[0] <= mxn_k_r;
      myn_dl_r[0] <= myn_k_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        mxn_dl_r[k] <= mxn_dl_r[k-1];
        myn_dl_r[k] <= myn_dl_r[k-1];
      end
      sb_dl_r[0] <= sb_g_r;
      for (int k = 1; k < SB_D; k++) sb_dl_r[k] <= sb_dl_r[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage l and tangent dividers: t = round(m * 2^F / len)
  // ---------------------------------------------------------------------
  logic [TDW-1:0]         dvx_l_r, dvy_l_r;
  logic [SQRT_STAGES-1:0] len_l_r;
  logic [TW-1:0]          tmx_q, tmy_q;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dvx_l_r <= TDW'({mxn_dl_r[SQRT_STAGES-1], {FRAC_BITS{1'b0}}})
               + TDW'(len_q[SQRT_STAGES-1:1]);
      dvy_l_r <= TDW'({myn_dl_r[SQRT_STAGES-1], {FRAC_BITS{1'b0}}})
               + TDW'(len_q[SQRT_STAGES-1:1]);
      len_l_r <= len_q;
    end
  end

  bsv_div_pipe #(
    .DVD_W(TDW),
    .DVS_W(SQRT_STAGES),
    .QUO_W(TW)
  ) u_tdiv_x (
    .clk (clk),
    .en  (pipe_en),
    .dvd (dvx_l_r),
    .dvs (len_l_r),
    .quo (tmx_q)
  );

  bsv_div_pipe #(
    .DVD_W(TDW),
    .DVS_W(SQRT_STAGES),
    .QUO_W(TW)
  ) u_tdiv_y (
    .clk (clk),
    .en  (pipe_en),
    .dvd (dvy_l_r),
    .dvs (len_l_r),
    .quo (tmy_q)
  );

  // ---------------------------------------------------------------------
  // stages m, n: half-width offsets; perpendicular is (t.y, -t.x)
  // ---------------------------------------------------------------------
  logic [OPW-1:0] pofx_m_r, pofy_m_r;
  logic [RW-1:0]  rofx_n_r, rofy_n_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pofx_m_r <= OPW'(tmy_q) * OPW'(wid_r);
      pofy_m_r <= OPW'(tmx_q) * OPW'(wid_r);
      // magnitude rounded half away from zero, sign applied afterwards
      rofx_n_r <= RW'((pofx_m_r + O_HALF) >> (FRAC_BITS + 1));
      rofy_n_r <= RW'((pofy_m_r + O_HALF) >> (FRAC_BITS + 1));
    end
  end

  // ---------------------------------------------------------------------
  // output register: edge sums with saturation
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] lx_r, ly_r, rx_r, ry_r;
  logic                      dg_r;
  logic signed [COORD_W-1:0] lx_nxt, ly_nxt, rx_nxt, ry_nxt;

  always_comb begin
    sb_t                  sb;
    logic signed [EW-1:0] pcx, pcy, ofx, ofy;
    sb  = sb_dl_r[SB_D-1];
    pcx = EW'(sb.pc_x);
    pcy = EW'(sb.pc_y);
    ofx = $signed({{(EW-RW){1'b0}}, rofx_n_r});
    ofy = $signed({{(EW-RW){1'b0}}, rofy_n_r});
    if (sb.neg_y) ofx = -ofx;
    if (sb.neg_x) ofy = -ofy;
    if (sb.degen) begin
      // zero derivative: both edges sit on the curve point
      lx_nxt = sat32(pcx);
      ly_nxt = sat32(pcy);
      rx_nxt = sat32(pcx);
      ry_nxt = sat32(pcy);
    end else begin
      lx_nxt = sat32(pcx - ofx);
      ly_nxt = sat32(pcy + ofy);
      rx_nxt = sat32(pcx + ofx);
      ry_nxt = sat32(pcy - ofy);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      dg_r <= sb_dl_r[SB_D-1].degen;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_left_x             = lx_r;
  assign out_left_y             = ly_r;
  assign out_right_x            = rx_r;
  assign out_right_y            = ry_r;
  assign out_degenerate_tangent = dg_r;

endmodule

// ===== rtl/bsv_checker.sv =====
`timescale 1ns / 1ps

module bsv_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [bsv_pkg::COORD_W-1:0] out_left_x,
  input logic signed [bsv_pkg::COORD_W-1:0] out_left_y,
  input logic signed [bsv_pkg::COORD_W-1:0] out_right_x,
  input logic signed [bsv_pkg::COORD_W-1:0] out_right_y,
  input logic                               out_degenerate_tangent
);

  // empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with output stage empty");

  // degenerate tangent collapses both edges onto the curve point
  a_degen_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate_tangent |->
      out_left_x == out_right_x && out_left_y == out_right_y)
    else $error("degenerate item with distinct edges");

  // stalled result stays valid and keeps its left x and right y
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_left_x) && $stable(out_right_y))
    else $error("stalled item changed or dropped");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bezier_strip_vertex_pair bsv_checker u_bsv_checker (.*);
